FILE: rtl/core/pf_pkg.sv
package pf_pkg;

  localparam int Side       = 5;
  localparam int NumRegs    = Side;
  localparam int LetterBits = 5;
  localparam int RowBits    = Side * LetterBits;
  localparam int PosBits    = 3;
  localparam int AddrBits   = 5;
  localparam int DataBits   = 32;

  localparam logic [LetterBits-1:0] LetterI = 5'd8;
  localparam logic [LetterBits-1:0] LetterJ = 5'd9;
  localparam logic [LetterBits-1:0] LetterX = 5'd23;

  typedef logic [LetterBits-1:0]      letter_t;
  typedef logic [PosBits-1:0]         pos_t;
  typedef logic [RowBits-1:0]         row_t;
  typedef row_t [Side-1:0]            square_t;
  typedef logic [Side*Side-1:0]       match_t;

  // Stage 1 result: one hit bit per cell for each letter.
  typedef struct packed {
    match_t match_a;
    match_t match_b;
    logic   doubled;
  } hits_t;

  // Stage 2 result: square coordinates of both letters.
  typedef struct packed {
    pos_t ra;
    pos_t ca;
    pos_t rb;
    pos_t cb;
    logic found;
    logic doubled;
  } coords_t;

  // Stage 3 result: the enciphered pair.
  typedef struct packed {
    letter_t ea;
    letter_t eb;
    logic    missing;
    logic    doubled;
  } pair_t;

  function automatic pos_t first_one(input logic [Side-1:0] v);
    pos_t p;
    p = '0;
    for (int k = Side - 1; k >= 0; k--) begin
      if (v[k]) begin
        p = pos_t'(k);
      end
    end
    return p;
  endfunction

  function automatic pos_t inc_wrap(input pos_t p);
    pos_t n;
    if (p == pos_t'(Side - 1)) begin
      n = '0;
    end else begin
      n = p + pos_t'(1);
    end
    return n;
  endfunction

  function automatic letter_t cell_at(input square_t sq, input pos_t r, input pos_t c);
    row_t row;
    row = sq[r];
    return row[c * LetterBits +: LetterBits];
  endfunction

endpackage

FILE: rtl/core/pf_regs.sv
module pf_regs
  import pf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  output square_t             square_o
);

  square_t rows_q;
  logic    wr_en;
  pos_t    idx;

  assign pready = 1'b1;
  assign idx    = paddr[AddrBits-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (wr_en && (idx < pos_t'(NumRegs))) begin
      rows_q[idx] <= pwdata[RowBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < pos_t'(NumRegs)) begin
      prdata = {{(DataBits - RowBits){1'b0}}, rows_q[idx]};
    end
  end

  assign square_o = rows_q;

endmodule

FILE: rtl/core/pf_locate.sv
module pf_locate
  import pf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  square_t square_i,
  input  logic    valid_i,
  output logic    ready_o,
  input  letter_t first_i,
  input  letter_t second_i,
  output logic    valid_o,
  input  logic    ready_i,
  output coords_t coords_o
);

  logic    v1_q, v2_q;
  logic    rdy1, rdy2;
  hits_t   hits_d, hits_q;
  coords_t coords_d, coords_q;
  letter_t a, b, b_fold;
  logic [Side-1:0] row_a, row_b;
  pos_t    ra, rb;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // Stage 1: fold j onto i, handle doubled letters, compare against all cells.
  always_comb begin
    a      = (first_i == LetterJ) ? LetterI : first_i;
    b_fold = (second_i == LetterJ) ? LetterI : second_i;
    hits_d.doubled = (a == b_fold);
    b      = hits_d.doubled ? LetterX : b_fold;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        hits_d.match_a[r * Side + c] = (square_i[r][c * LetterBits +: LetterBits] == a);
        hits_d.match_b[r * Side + c] = (square_i[r][c * LetterBits +: LetterBits] == b);
      end
    end
  end

  // Stage 2: first hit in row-major order, row first and then column.
  always_comb begin
    for (int r = 0; r < Side; r++) begin
      row_a[r] = |hits_q.match_a[r * Side +: Side];
      row_b[r] = |hits_q.match_b[r * Side +: Side];
    end
    ra = first_one(row_a);
    rb = first_one(row_b);
    coords_d.ra      = ra;
    coords_d.rb      = rb;
    coords_d.ca      = first_one(hits_q.match_a[ra * Side +: Side]);
    coords_d.cb      = first_one(hits_q.match_b[rb * Side +: Side]);
    coords_d.found   = (|row_a) && (|row_b);
    coords_d.doubled = hits_q.doubled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      hits_q <= hits_d;
    end
    if (rdy2 && v1_q) begin
      coords_q <= coords_d;
    end
  end

  assign valid_o  = v2_q;
  assign coords_o = coords_q;

endmodule

FILE: rtl/core/pf_subst.sv
module pf_subst
  import pf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  square_t square_i,
  input  logic    valid_i,
  output logic    ready_o,
  input  coords_t coords_i,
  output logic    valid_o,
  input  logic    ready_i,
  output pair_t   pair_o
);

  logic  v3_q;
  pair_t pair_d, pair_q;
  pos_t  ra_n, rb_n, ca_n, cb_n;

  assign ready_o = !v3_q || ready_i;

  always_comb begin
    ra_n = coords_i.ra;
    rb_n = coords_i.rb;
    ca_n = coords_i.ca;
    cb_n = coords_i.cb;
    if (coords_i.ca == coords_i.cb) begin
      ra_n = inc_wrap(coords_i.ra);
      rb_n = inc_wrap(coords_i.rb);
    end else if (coords_i.ra == coords_i.rb) begin
      ca_n = inc_wrap(coords_i.ca);
      cb_n = inc_wrap(coords_i.cb);
    end else begin
      // Rectangle: each letter keeps its row and takes the other column.
      ca_n = coords_i.cb;
      cb_n = coords_i.ca;
    end
    pair_d.missing = !coords_i.found;
    pair_d.doubled = coords_i.doubled;
    pair_d.ea      = coords_i.found ? cell_at(square_i, ra_n, ca_n) : '0;
    pair_d.eb      = coords_i.found ? cell_at(square_i, rb_n, cb_n) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ready_o) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pair_q <= pair_d;
    end
  end

  assign valid_o = v3_q;
  assign pair_o  = pair_q;

endmodule

FILE: rtl/core/pf_serial.sv
module pf_serial
  import pf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  pair_t   pair_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output letter_t cipher_letter_o,
  output logic    letter_missing_o,
  output logic    last_of_run_o
);

  logic       sv_q;
  pair_t      pair_q;
  logic [1:0] cnt_q;
  logic       last, xfer;

  assign last  = pair_q.doubled ? (cnt_q == 2'd3) : (cnt_q == 2'd1);
  assign xfer  = sv_q && out_ready_i;
  // A new pair loads as the last letter of the current one is transferred.
  assign ready_o = !sv_q || (xfer && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q  <= 1'b0;
      cnt_q <= '0;
    end else if (ready_o) begin
      sv_q  <= valid_i;
      cnt_q <= '0;
    end else if (xfer) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pair_q <= pair_i;
    end
  end

  assign out_valid_o      = sv_q;
  assign cipher_letter_o  = cnt_q[0] ? pair_q.eb : pair_q.ea;
  assign letter_missing_o = pair_q.missing;
  assign last_of_run_o    = last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q && !pair_q.doubled |-> cnt_q <= 2'd1)
    else $error("letter count ran past a plain pair");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !last |=> sv_q && cnt_q == $past(cnt_q) + 2'd1)
    else $error("letter index did not advance after a transfer");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && last && !valid_i |=> !sv_q)
    else $error("output stayed valid after the last letter with nothing queued");

endmodule

FILE: rtl/core/playfair_digraph_encrypt_unit.sv
// Playfair digraph encryption unit.
//
// The key square is written through the APB port: matrix_row0..4 at byte
// addresses 0x00..0x10, five 5-bit letter codes per row, column 0 lowest.
// Write the square only while no pair is in flight.
//
// A letter pair enters on the input channel (in_valid_i / in_ready_o) and
// leaves as single ciphertext letters on the output channel. A plain pair
// gives two letters; a doubled pair gives four, the pair (letter, x) twice.
// last_of_run_o marks the final letter of each pair, and letter_missing_o
// is set on every letter of a pair with a letter absent from the square.
//
// Four register stages: cell compare, position encode, substitution and the
// output serializer. A pair stays in the single-letter output register until
// its last letter is transferred, and the next pair loads as that letter
// leaves, so new pairs enter while earlier ones are still in the stages.
// When the receiver stalls, the stages fill up and in_ready_o drops; nothing
// is lost or repeated.
// Reset clears all valid bits and sets the key square to zero.
module playfair_digraph_encrypt_unit
  import pf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  letter_t             first_letter_i,
  input  letter_t             second_letter_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output letter_t             cipher_letter_o,
  output logic                letter_missing_o,
  output logic                last_of_run_o
);

  square_t square;
  coords_t coords;
  pair_t   pair;
  logic    loc_valid, loc_ready;
  logic    sub_valid, sub_ready;

  pf_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .square_o (square)
  );

  pf_locate u_locate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .square_i (square),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .first_i  (first_letter_i),
    .second_i (second_letter_i),
    .valid_o  (loc_valid),
    .ready_i  (loc_ready),
    .coords_o (coords)
  );

  pf_subst u_subst (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .square_i (square),
    .valid_i  (loc_valid),
    .ready_o  (loc_ready),
    .coords_i (coords),
    .valid_o  (sub_valid),
    .ready_i  (sub_ready),
    .pair_o   (pair)
  );

  pf_serial u_serial (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (sub_valid),
    .ready_o          (sub_ready),
    .pair_i           (pair),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cipher_letter_o  (cipher_letter_o),
    .letter_missing_o (letter_missing_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

FILE: tb/playfair_digraph_encrypt_unit_tb.sv
module playfair_digraph_encrypt_unit_tb;
  import pf_pkg::*;

  localparam int RegStride     = 4;
  localparam int AlphabetSize  = 26;
  localparam int CodeMax       = 31;
  localparam int SettleCycles  = 8;
  localparam int LongHold      = 80;
  localparam int RandomPhases  = 5;
  localparam int PairsPerPhase = 26;
  localparam int CycleLimit    = 200000;

  typedef enum int {
    MatrixRow0,
    MatrixRow1,
    MatrixRow2,
    MatrixRow3,
    MatrixRow4
  } matrix_reg_e;

  typedef struct packed {
    letter_t letter;
    logic    missing;
    logic    last_flag;
  } cipher_out_t;

  class cipher_scoreboard;
    square_t     square;
    cipher_out_t expected_letters[$];
    int          errors;

    function new();
      square = '0;
      errors = 0;
    endfunction

    function letter_t square_cell(int r, int c);
      return square[r][c * LetterBits +: LetterBits];
    endfunction

    // Lookup takes the first matching cell in row-major order.
    function bit locate_letter(letter_t code, output int r, output int c);
      r = 0;
      c = 0;
      for (int k = 0; k < Side * Side; k++) begin
        if (square_cell(k / Side, k % Side) == code) begin
          r = k / Side;
          c = k % Side;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void encipher(letter_t a, letter_t b);
      int      ra, ca, rb, cb;
      bit      fa, fb;
      letter_t ea, eb;
      fa = locate_letter(a, ra, ca);
      fb = locate_letter(b, rb, cb);
      if (!(fa && fb)) begin
        expected_letters.push_back(cipher_out_t'{letter: '0, missing: 1'b1, last_flag: 1'b0});
        expected_letters.push_back(cipher_out_t'{letter: '0, missing: 1'b1, last_flag: 1'b0});
        return;
      end
      if (ca == cb) begin
        ea = square_cell((ra + 1) % Side, ca);
        eb = square_cell((rb + 1) % Side, cb);
      end else if (ra == rb) begin
        ea = square_cell(ra, (ca + 1) % Side);
        eb = square_cell(rb, (cb + 1) % Side);
      end else begin
        ea = square_cell(ra, cb);
        eb = square_cell(rb, ca);
      end
      expected_letters.push_back(cipher_out_t'{letter: ea, missing: 1'b0, last_flag: 1'b0});
      expected_letters.push_back(cipher_out_t'{letter: eb, missing: 1'b0, last_flag: 1'b0});
    endfunction

    function void note_pair(letter_t first, letter_t second);
      letter_t a, b;
      a = (first == LetterJ) ? LetterI : first;
      b = (second == LetterJ) ? LetterI : second;
      if (a == b) begin
        encipher(a, LetterX);
        encipher(a, LetterX);
      end else begin
        encipher(a, b);
      end
      expected_letters[expected_letters.size() - 1].last_flag = 1'b1;
    endfunction

    function void check_letter(letter_t letter, logic missing, logic last_flag);
      cipher_out_t want;
      if (expected_letters.size() == 0) begin
        $error("cipher letter %0d arrived with no pair outstanding", letter);
        errors++;
        return;
      end
      want = expected_letters.pop_front();
      if (letter !== want.letter) begin
        $error("cipher_letter: expected %0d, got %0d", want.letter, letter);
        errors++;
      end
      if (missing !== want.missing) begin
        $error("letter_missing: expected %0d, got %0d", want.missing, missing);
        errors++;
      end
      if (last_flag !== want.last_flag) begin
        $error("last_of_run: expected %0d, got %0d", want.last_flag, last_flag);
        errors++;
      end
    endfunction

    function int pending();
      return expected_letters.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [AddrBits-1:0] paddr           = '0;
  logic [DataBits-1:0] pwdata          = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  letter_t             first_letter_i  = '0;
  letter_t             second_letter_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  letter_t             cipher_letter_o;
  logic                letter_missing_o;
  logic                last_of_run_o;

  logic tx_steady    = 1'b0;
  logic rx_steady    = 1'b0;
  logic hold_request = 1'b0;

  cipher_scoreboard sb;

  playfair_digraph_encrypt_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_letter_i  (first_letter_i),
    .second_letter_i (second_letter_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cipher_letter_o (cipher_letter_o),
    .letter_missing_o(letter_missing_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    for (int n = 0; n < CycleLimit; n++) begin
      @(posedge clk_i);
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic letter_t ltr(input byte ch);
    return letter_t'(ch - "a");
  endfunction

  function automatic square_t pack_square(input string s);
    square_t sq;
    for (int k = 0; k < Side * Side; k++) begin
      sq[k / Side][(k % Side) * LetterBits +: LetterBits] = ltr(s[k]);
    end
    return sq;
  endfunction

  function automatic square_t random_square();
    int      cells [Side*Side];
    int      n;
    int      j;
    int      t;
    square_t sq;
    n = 0;
    for (int code = 0; code < AlphabetSize; code++) begin
      if (code != LetterJ) begin
        cells[n] = code;
        n++;
      end
    end
    for (int k = Side * Side - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = cells[k];
      cells[k] = cells[j];
      cells[j] = t;
    end
    // Some squares get stray codes, so letters go missing and others repeat.
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        cells[$urandom_range(0, Side * Side - 1)] = $urandom_range(0, CodeMax);
      end
    end
    for (int k = 0; k < Side * Side; k++) begin
      sq[k / Side][(k % Side) * LetterBits +: LetterBits] = letter_t'(cells[k]);
    end
    return sq;
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(20, 40);
  endfunction

  // Each register transfer leaves psel high; apb_idle closes a burst.
  task automatic apb_transfer(input int idx, input logic wr, input row_t value,
                              output logic [DataBits-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrBits'(idx * RegStride);
    pwdata  <= DataBits'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_square(input square_t sq);
    logic [DataBits-1:0] rdata;
    for (int i = MatrixRow0; i <= MatrixRow4; i++) begin
      apb_transfer(i, 1'b1, sq[i], rdata);
    end
    for (int i = MatrixRow0; i <= MatrixRow4; i++) begin
      apb_transfer(i, 1'b0, '0, rdata);
      if (rdata[RowBits-1:0] !== sq[i]) begin
        $error("matrix_row%0d readback: expected %h, got %h", i, sq[i], rdata[RowBits-1:0]);
        sb.errors++;
      end
    end
    apb_idle();
    sb.square = sq;
  endtask

  task automatic send_pair(input letter_t a, input letter_t b);
    in_valid_i      <= 1'b1;
    first_letter_i  <= a;
    second_letter_i <= b;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_pair(a, b);
  endtask

  task automatic offer_pair(input letter_t a, input letter_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    send_pair(a, b);
  endtask

  // The sender pauses here until every letter of the phase has come back.
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int hold_left;
    int stall_left;
    int r;
    hold_left  = 0;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_letter(cipher_letter_o, letter_missing_o, last_of_run_o);
      end
      if (hold_request) begin
        hold_left = LongHold;
        hold_request <= 1'b0;
      end
      if (hold_left == 0 && stall_left == 0 && !rx_steady) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          stall_left = $urandom_range(1, 3);
        end else if (r < 14) begin
          stall_left = $urandom_range(15, 40);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    square_t std_square;
    square_t sq;
    letter_t a;
    letter_t b;
    int      r;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-zero square: only code a is present anywhere.
    apply_square('0);
    offer_pair(ltr("a"), ltr("a"));
    offer_pair(ltr("a"), ltr("b"));
    offer_pair(ltr("z"), ltr("a"));
    finish_phase();

    // Every cell holds code 31, so every lookup fails.
    apply_square('1);
    offer_pair(ltr("a"), ltr("z"));
    offer_pair(ltr("q"), ltr("q"));
    finish_phase();

    std_square = pack_square("playfirexmbcdghknoqstuvwz");
    apply_square(std_square);
    offer_pair(ltr("p"), ltr("f"));
    offer_pair(ltr("r"), ltr("e"));
    offer_pair(ltr("f"), ltr("z"));
    offer_pair(ltr("h"), ltr("e"));
    offer_pair(ltr("a"), ltr("z"));
    offer_pair(ltr("z"), ltr("a"));
    offer_pair(ltr("l"), ltr("l"));
    offer_pair(ltr("x"), ltr("x"));
    offer_pair(ltr("j"), ltr("i"));
    offer_pair(ltr("j"), ltr("k"));
    offer_pair(ltr("b"), ltr("j"));
    offer_pair(ltr("a"), ltr("a"));
    offer_pair(ltr("z"), ltr("z"));
    finish_phase();

    // Drop w for a stray code and put a second a where q was.
    sq = std_square;
    sq[4][3 * LetterBits +: LetterBits] = letter_t'(CodeMax);
    sq[3][3 * LetterBits +: LetterBits] = ltr("a");
    apply_square(sq);
    offer_pair(ltr("w"), ltr("a"));
    offer_pair(ltr("q"), ltr("b"));
    offer_pair(ltr("a"), ltr("d"));
    offer_pair(ltr("o"), ltr("a"));
    finish_phase();

    for (int p = 0; p < RandomPhases; p++) begin
      apply_square(random_square());
      tx_steady <= (p <= 1);
      rx_steady <= (p == 0);
      // The receiver holds off long enough for the pipeline to back up.
      if (p == 1) begin
        hold_request <= 1'b1;
      end
      for (int i = 0; i < PairsPerPhase; i++) begin
        r = $urandom_range(0, 7);
        a = letter_t'($urandom_range(0, AlphabetSize - 1));
        if (r == 0) begin
          b = a;
        end else if (r == 1) begin
          b = LetterJ;
        end else begin
          b = letter_t'($urandom_range(0, AlphabetSize - 1));
        end
        offer_pair(a, b);
      end
      finish_phase();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
